[rtl/core/scl_pkg.sv]
// scl_pkg: shared constants for the sine/cosine table interpolator
// fixed-point pi and series divisors used to build the quarter-wave rom
// no dependencies
package scl_pkg;

  // working precision of the table build, radians in q30
  localparam int unsigned QBITS = 30;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // number of odd terms after x in the sine series
  localparam int unsigned SERIES_TERMS = 8;

  // (2i)*(2i+1) for i = 1 .. SERIES_TERMS
  localparam logic [63:0] SERIES_DIV [1:SERIES_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

endpackage

[rtl/core/sine_cosine_lut_interpolator.sv]
// sine_cosine_lut_interpolator: sine or cosine of a binary angle
// five register stages: fold, segment, rom read, slope multiply, round and sign
// one word per cycle sustained while the output is ready; output backpressure stalls
// only the stages that hold data, bubbles collapse
// rst_n is synchronous and clears the stage valid bits only
// depends on scl_pkg through scl_quarter_rom
module sine_cosine_lut_interpolator #(
  parameter int TABLE_SEGMENTS = 128,
  parameter int ANGLE_BITS     = 16,
  parameter int OUT_FRAC_BITS  = 15
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((ANGLE_BITS+7)/8)*8-1:0]        in_tdata,   // angle
  input  logic                                   in_tuser,   // kind: 0 sine, 1 cosine
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((OUT_FRAC_BITS+8)/8)*8-1:0]     out_tdata   // value
);

  localparam int AW     = ANGLE_BITS;
  localparam int QB     = ANGLE_BITS - 2;
  localparam int F      = OUT_FRAC_BITS;
  localparam int SW     = $clog2(TABLE_SEGMENTS + 1);
  localparam int PW     = QB + SW;
  localparam int ACC_W  = F + QB + 2;
  localparam int OUT_TW = ((OUT_FRAC_BITS + 8) / 8) * 8;

  localparam logic [AW-1:0]           QTR_A = {2'b01, {QB{1'b0}}};
  localparam logic [QB:0]             QTR_O = {1'b1, {QB{1'b0}}};
  localparam logic [SW-1:0]           SEGS  = SW'(TABLE_SEGMENTS);
  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) << (QB - 1);
  localparam logic signed [F+1:0]     MAXS  = (F+2)'((longint'(1) << F) - 1);

  // stage valid bits and ready chain, stage 5 is the output register
  logic [5:1] v_r;
  logic [5:1] rdy;

  assign rdy[5]    = !v_r[5] || out_tready;
  assign rdy[4]    = !v_r[4] || rdy[5];
  assign rdy[3]    = !v_r[3] || rdy[4];
  assign rdy[2]    = !v_r[2] || rdy[3];
  assign rdy[1]    = !v_r[1] || rdy[2];
  assign in_tready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_tvalid;
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
      if (rdy[4]) v_r[4] <= v_r[3];
      if (rdy[5]) v_r[5] <= v_r[4];
    end
  end

  // stage 1: quarter turn for cosine, quadrant fold
  logic [AW-1:0] ang;
  logic [QB-1:0] ofs;
  logic [QB:0]   off_nxt, off_r;
  logic          neg1_r;

  always_comb begin
    ang     = in_tdata[AW-1:0] + (in_tuser ? QTR_A : '0);
    ofs     = ang[QB-1:0];
    off_nxt = ang[AW-2] ? (QTR_O - {1'b0, ofs}) : {1'b0, ofs};
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      off_r  <= off_nxt;
      neg1_r <= ang[AW-1];
    end
  end

  // stage 2: segment index and fraction
  logic [PW-1:0] pos;
  logic [SW-1:0] idx1, idx2, idx1_r, idx2_r;
  logic [QB-1:0] frac2_r;
  logic          neg2_r;

  always_comb begin
    pos  = PW'(off_r) * PW'(SEGS);
    idx1 = pos[PW-1:QB];
    // only the quadrant peak lands on the last point, with zero fraction
    idx2 = (idx1 == SEGS) ? idx1 : idx1 + SW'(1);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      idx1_r  <= idx1;
      idx2_r  <= idx2;
      frac2_r <= pos[QB-1:0];
      neg2_r  <= neg1_r;
    end
  end

  // stage 3: table read
  logic [F-1:0]  y1_r, y2_r;
  logic [QB-1:0] frac3_r;
  logic          neg3_r;

  scl_quarter_rom #(
    .SEGMENTS  (TABLE_SEGMENTS),
    .FRAC_BITS (F)
  ) u_rom (
    .clk      (clk),
    .en       (rdy[3]),
    .addr_a   (idx1_r),
    .addr_b   (idx2_r),
    .data_a_r (y1_r),
    .data_b_r (y2_r)
  );

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      frac3_r <= frac2_r;
      neg3_r  <= neg2_r;
    end
  end

  // stage 4: slope times fraction
  logic signed [F:0]       dy;
  logic signed [QB:0]      fr;
  logic signed [ACC_W-1:0] prod_nxt, prod_r;
  logic [F-1:0]            y1b_r;
  logic                    neg4_r;

  always_comb begin
    dy       = $signed({1'b0, y2_r}) - $signed({1'b0, y1_r});
    fr       = $signed({1'b0, frac3_r});
    prod_nxt = dy * fr;
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      prod_r <= prod_nxt;
      y1b_r  <= y1_r;
      neg4_r <= neg3_r;
    end
  end

  // stage 5: round, clamp, restore sign
  logic signed [ACC_W-1:0] acc;
  logic signed [F+1:0]     mag;
  logic [F:0]              val;
  logic [F:0]              val_nxt, val_r;

  always_comb begin
    acc     = $signed({2'b00, y1b_r, {QB{1'b0}}}) + prod_r + HALF;
    mag     = acc[ACC_W-1:QB];
    val     = (mag > MAXS) ? MAXS[F:0] : mag[F:0];
    val_nxt = neg4_r ? (~val + (F+1)'(1)) : val;
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      val_r <= val_nxt;
    end
  end

  assign out_tvalid = v_r[5];
  assign out_tdata  = OUT_TW'(val_r);

endmodule

[rtl/core/scl_quarter_rom.sv]
// scl_quarter_rom: quarter-wave sine rom, entries built at elaboration
// two registered read ports sharing one enable
// depends on scl_pkg
module scl_quarter_rom
  import scl_pkg::*;
#(
  parameter int SEGMENTS  = 128,
  parameter int FRAC_BITS = 15
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [$clog2(SEGMENTS+1)-1:0]      addr_a,
  input  logic [$clog2(SEGMENTS+1)-1:0]      addr_b,
  output logic [FRAC_BITS-1:0]               data_a_r,
  output logic [FRAC_BITS-1:0]               data_b_r
);

  localparam longint RND     = longint'(1) << (QBITS - FRAC_BITS - 1);
  localparam int     SHIFT   = QBITS - FRAC_BITS;
  localparam longint OUT_MAX = (longint'(1) << FRAC_BITS) - 1;

  logic [FRAC_BITS-1:0] rom [0:SEGMENTS];

  for (genvar k = 0; k <= SEGMENTS; k++) begin : g_entry
    localparam logic [63:0] X  = (64'(k) * PI_Q30 + 64'(SEGMENTS)) / (64'(2 * SEGMENTS));
    localparam logic [63:0] X2 = (X * X) >> QBITS;
    localparam logic [63:0] T1 = ((X  * X2) >> QBITS) / SERIES_DIV[1];
    localparam logic [63:0] T2 = ((T1 * X2) >> QBITS) / SERIES_DIV[2];
    localparam logic [63:0] T3 = ((T2 * X2) >> QBITS) / SERIES_DIV[3];
    localparam logic [63:0] T4 = ((T3 * X2) >> QBITS) / SERIES_DIV[4];
    localparam logic [63:0] T5 = ((T4 * X2) >> QBITS) / SERIES_DIV[5];
    localparam logic [63:0] T6 = ((T5 * X2) >> QBITS) / SERIES_DIV[6];
    localparam logic [63:0] T7 = ((T6 * X2) >> QBITS) / SERIES_DIV[7];
    localparam logic [63:0] T8 = ((T7 * X2) >> QBITS) / SERIES_DIV[8];
    localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                           + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7)
                           + longint'(T8);
    localparam longint SUMC = (SUM < 0) ? longint'(0) : SUM;
    localparam longint V    = (SUMC + RND) >>> SHIFT;
    localparam longint VC   = (V > OUT_MAX) ? OUT_MAX : V;
    assign rom[k] = FRAC_BITS'(VC);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_a_r <= rom[addr_a];
      data_b_r <= rom[addr_b];
    end
  end

endmodule

[rtl/core/scl_checker.sv]
// scl_checker: port-level checks for sine_cosine_lut_interpolator
// bound to the top level below; depends on nothing else
module scl_checker #(
  parameter int TABLE_SEGMENTS = 128,
  parameter int ANGLE_BITS     = 16,
  parameter int OUT_FRAC_BITS  = 15
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_tvalid,
  input logic                                   in_tready,
  input logic [((ANGLE_BITS+7)/8)*8-1:0]        in_tdata,
  input logic                                   in_tuser,
  input logic                                   out_tvalid,
  input logic                                   out_tready,
  input logic [((OUT_FRAC_BITS+8)/8)*8-1:0]     out_tdata
);

  localparam int F = OUT_FRAC_BITS;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // input is held off only by a full pipeline behind a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // magnitude saturates, so the most negative code never appears
  a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[F] |-> out_tdata[F-1:0] != '0)
    else $error("output holds the most negative code");

endmodule

bind sine_cosine_lut_interpolator scl_checker #(
  .TABLE_SEGMENTS (TABLE_SEGMENTS),
  .ANGLE_BITS     (ANGLE_BITS),
  .OUT_FRAC_BITS  (OUT_FRAC_BITS)
) u_scl_checker (.*);
